// ===== hdl/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH     = 32;
  localparam int DEF_MAX_PRECISION = 24;

  // Octal needs the most digits for 32 bits
  localparam int DIG_MAX = 11;
  localparam int DIG_W   = $clog2(DIG_MAX + 1);
  // Covers prefix, widest field and longest precision run
  localparam int CNT_W   = 7;
  localparam int FW_W    = 6;
  localparam int PREC_W  = 5;

  // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_UDEC = 3'd1;
  localparam logic [2:0] FUNC_OCT  = 3'd2;
  localparam logic [2:0] FUNC_LHEX = 3'd3;
  localparam logic [2:0] FUNC_UHEX = 3'd4;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_SETUP,
    ST_PRE0,
    ST_PREX,
    ST_SIGN_ZP,
    ST_PAD_L,
    ST_SIGN_SP,
    ST_PREC,
    ST_DIGITS,
    ST_PAD_R
  } step_t;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_EXTRACT,
    OP_SETUP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ADV_IN_BEAT,
    ADV_MAG_ZERO,
    ADV_ALWAYS,
    ADV_STEP_DONE
  } adv_sel_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ALT_PFX,
    COND_ALT_HEX,
    COND_SIGN_ZP,
    COND_RIGHT_ALIGN,
    COND_SIGN_SP,
    COND_LEFT_ALIGN
  } cond_t;

  typedef enum logic [1:0] {
    CNT_ONE,
    CNT_PAD,
    CNT_PRECX,
    CNT_DIGITS
  } cnt_sel_t;

  typedef enum logic [2:0] {
    CHR_ZERO,
    CHR_X,
    CHR_SIGN,
    CHR_PAD_L,
    CHR_SPACE,
    CHR_DIGIT
  } chr_sel_t;

  typedef struct packed {
    op_t      op;
    adv_sel_t adv_sel;
    cond_t    cond;
    cnt_sel_t cnt_sel;
    chr_sel_t chr_sel;
    step_t    next;
  } uword_t;

  typedef struct packed {
    logic in_beat;
    logic mag_zero;
    logic step_done;
    logic chars_zero;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] rem, input logic upper);
    logic [7:0] c;
    if (rem < 4'd10) begin
      c = CH_ZERO + {4'd0, rem};
    end else begin
      c = (upper ? CH_UA : CH_LA) + {4'd0, rem} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itf_useq.sv =====
`default_nettype none

module itf_useq (
  input  wire                 clk,
  input  wire                 rst,
  input  itf_pkg::status_t    status,
  output itf_pkg::step_t      step,
  output itf_pkg::uword_t     uword
);

  itf_pkg::step_t step_next;
  logic           adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= itf_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Control store
  always_comb begin
    unique case (step)
      itf_pkg::ST_IDLE:    uword = '{itf_pkg::OP_WAIT, itf_pkg::ADV_IN_BEAT,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_EXTRACT};
      itf_pkg::ST_EXTRACT: uword = '{itf_pkg::OP_EXTRACT, itf_pkg::ADV_MAG_ZERO,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_SETUP};
      itf_pkg::ST_SETUP:   uword = '{itf_pkg::OP_SETUP, itf_pkg::ADV_ALWAYS,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_PRE0};
      itf_pkg::ST_PRE0:    uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_ALT_PFX, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_PREX};
      itf_pkg::ST_PREX:    uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_ALT_HEX, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_X, itf_pkg::ST_SIGN_ZP};
      itf_pkg::ST_SIGN_ZP: uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_SIGN_ZP, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_SIGN, itf_pkg::ST_PAD_L};
      itf_pkg::ST_PAD_L:   uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_RIGHT_ALIGN, itf_pkg::CNT_PAD,
                                     itf_pkg::CHR_PAD_L, itf_pkg::ST_SIGN_SP};
      itf_pkg::ST_SIGN_SP: uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_SIGN_SP, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_SIGN, itf_pkg::ST_PREC};
      itf_pkg::ST_PREC:    uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_PRECX,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_DIGITS};
      itf_pkg::ST_DIGITS:  uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_DIGITS,
                                     itf_pkg::CHR_DIGIT, itf_pkg::ST_PAD_R};
      itf_pkg::ST_PAD_R:   uword = '{itf_pkg::OP_EMIT, itf_pkg::ADV_STEP_DONE,
                                     itf_pkg::COND_LEFT_ALIGN, itf_pkg::CNT_PAD,
                                     itf_pkg::CHR_SPACE, itf_pkg::ST_IDLE};
      default:             uword = '{itf_pkg::OP_WAIT, itf_pkg::ADV_IN_BEAT,
                                     itf_pkg::COND_ALWAYS, itf_pkg::CNT_ONE,
                                     itf_pkg::CHR_ZERO, itf_pkg::ST_IDLE};
    endcase
  end

  // Conditional jump: take the next field once the selected condition holds
  always_comb begin
    unique case (uword.adv_sel)
      itf_pkg::ADV_IN_BEAT:   adv = status.in_beat;
      itf_pkg::ADV_MAG_ZERO:  adv = status.mag_zero;
      itf_pkg::ADV_ALWAYS:    adv = 1'b1;
      itf_pkg::ADV_STEP_DONE: adv = status.step_done;
      default:                adv = 1'b0;
    endcase
    step_next = adv ? uword.next : step;
  end

endmodule

`default_nettype wire

// ===== hdl/itf_dpath.sv =====
`default_nettype none

module itf_dpath #(
  parameter int MAX_WIDTH     = itf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PRECISION = itf_pkg::DEF_MAX_PRECISION
) (
  input  wire                 clk,
  input  wire                 rst,
  input  itf_pkg::uword_t     uword,
  output itf_pkg::status_t    status,
  input  wire                 in_valid,
  input  wire  [31:0]         value,
  input  wire  [2:0]          func,
  input  wire                 zero_pad,
  input  wire                 left_align,
  input  wire                 alternate,
  input  wire                 force_plus,
  input  wire  [5:0]          field_width,
  input  wire  signed [5:0]   min_digits,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_char,
  output logic                last
);

  localparam int CW = itf_pkg::CNT_W;

  // Item registers
  logic [31:0]               mag;
  itf_pkg::base_t            base;
  logic                      upper;
  logic                      zpad_r;
  logic                      left_r;
  logic                      alt_r;
  logic                      has_sign;
  logic                      minus;
  logic [itf_pkg::FW_W-1:0]  width_r;
  logic [itf_pkg::PREC_W-1:0] prec_r;
  logic [itf_pkg::DIG_W-1:0] nd;
  logic [7:0]                stack [itf_pkg::DIG_MAX];
  logic [CW-1:0]             pad;
  logic [CW-1:0]             precx;
  logic [CW-1:0]             chars_left;
  logic [CW-1:0]             emit_cnt;

  logic                      in_beat;
  logic                      is_neg;
  logic [31:0]               mag_in;
  logic [63:0]               prod;
  logic [31:0]               quo;
  logic [31:0]               quo_x10;
  logic [31:0]               rem_full;
  logic [3:0]                rem;
  logic [7:0]                dig_ch;
  logic [CW-1:0]             used;
  logic [CW-1:0]             width_x;
  logic [CW-1:0]             prec_x;
  logic [CW-1:0]             nd_x;
  logic [CW-1:0]             pad_calc;
  logic [CW-1:0]             precx_calc;
  logic [CW-1:0]             pre_len;
  logic                      cond_ok;
  logic [CW-1:0]             cnt_src;
  logic [CW-1:0]             step_len;
  logic                      out_free;
  logic                      fire;
  logic                      step_done;
  logic [7:0]                ch;

  assign in_beat = in_valid && (uword.op == itf_pkg::OP_WAIT);
  assign is_neg  = (func == itf_pkg::FUNC_SDEC) && value[31];
  assign mag_in  = is_neg ? (32'd0 - value) : value;

  // One digit per cycle: shift for octal and hex, reciprocal multiply for decimal
  assign prod    = {32'd0, mag} * {32'd0, itf_pkg::DIV10_RECIP};
  assign quo_x10 = {quo[28:0], 3'd0} + {quo[30:0], 1'b0};
  assign rem_full = mag - quo_x10;

  always_comb begin
    case (base)
      itf_pkg::BASE_OCT: begin
        quo = {3'd0, mag[31:3]};
        rem = {1'b0, mag[2:0]};
      end
      itf_pkg::BASE_HEX: begin
        quo = {4'd0, mag[31:4]};
        rem = mag[3:0];
      end
      default: begin
        quo = {3'd0, prod[63:itf_pkg::DIV10_SHIFT]};
        rem = rem_full[3:0];
      end
    endcase
  end

  assign dig_ch = itf_pkg::digit_char(rem, upper);

  // Lengths of each run of characters
  assign nd_x     = CW'(nd);
  assign width_x  = CW'(width_r);
  assign prec_x   = CW'(prec_r);
  assign used     = nd_x + CW'(has_sign);
  assign pad_calc = (width_x > used) ? (width_x - used) : '0;
  assign precx_calc = (prec_x > nd_x) ? (prec_x - nd_x) : '0;
  always_comb begin
    pre_len = '0;
    if (alt_r && (base == itf_pkg::BASE_OCT)) pre_len = CW'(1);
    if (alt_r && (base == itf_pkg::BASE_HEX)) pre_len = CW'(2);
  end

  always_comb begin
    unique case (uword.cond)
      itf_pkg::COND_ALWAYS:      cond_ok = 1'b1;
      itf_pkg::COND_ALT_PFX:     cond_ok = alt_r && (base != itf_pkg::BASE_DEC);
      itf_pkg::COND_ALT_HEX:     cond_ok = alt_r && (base == itf_pkg::BASE_HEX);
      itf_pkg::COND_SIGN_ZP:     cond_ok = has_sign && !left_r && zpad_r;
      itf_pkg::COND_RIGHT_ALIGN: cond_ok = !left_r;
      itf_pkg::COND_SIGN_SP:     cond_ok = has_sign && (left_r || !zpad_r);
      itf_pkg::COND_LEFT_ALIGN:  cond_ok = left_r;
      default:                   cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uword.cnt_sel)
      itf_pkg::CNT_ONE:    cnt_src = CW'(1);
      itf_pkg::CNT_PAD:    cnt_src = pad;
      itf_pkg::CNT_PRECX:  cnt_src = precx;
      itf_pkg::CNT_DIGITS: cnt_src = nd_x;
      default:             cnt_src = '0;
    endcase
  end

  always_comb begin
    unique case (uword.chr_sel)
      itf_pkg::CHR_ZERO:  ch = itf_pkg::CH_ZERO;
      itf_pkg::CHR_X:     ch = itf_pkg::CH_X;
      itf_pkg::CHR_SIGN:  ch = minus ? itf_pkg::CH_MINUS : itf_pkg::CH_PLUS;
      itf_pkg::CHR_PAD_L: ch = zpad_r ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
      itf_pkg::CHR_SPACE: ch = itf_pkg::CH_SPACE;
      itf_pkg::CHR_DIGIT: ch = stack[0];
      default:            ch = itf_pkg::CH_SPACE;
    endcase
  end

  assign step_len  = cond_ok ? cnt_src : '0;
  assign out_free  = !out_valid || !out_stall;
  assign fire      = (uword.op == itf_pkg::OP_EMIT) && (emit_cnt < step_len) && out_free;
  assign step_done = (step_len == '0) || (fire && ((emit_cnt + CW'(1)) == step_len));

  assign status.in_beat    = in_beat;
  assign status.mag_zero   = (quo == 32'd0);
  assign status.step_done  = step_done;
  assign status.chars_zero = (chars_left == '0);

  // Capture the item and saturate width and precision; mag takes the quotient while extracting
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mag      <= mag_in;
      upper    <= (func == itf_pkg::FUNC_UHEX);
      zpad_r   <= zero_pad;
      left_r   <= left_align;
      alt_r    <= alternate;
      has_sign <= is_neg || force_plus;
      minus    <= is_neg;
      width_r  <= (field_width > itf_pkg::FW_W'(MAX_WIDTH)) ?
                  itf_pkg::FW_W'(MAX_WIDTH) : field_width;
      if (min_digits[5]) begin
        prec_r <= '0;
      end else begin
        prec_r <= (min_digits[4:0] > itf_pkg::PREC_W'(MAX_PRECISION)) ?
                  itf_pkg::PREC_W'(MAX_PRECISION) : min_digits[4:0];
      end
      case (func)
        itf_pkg::FUNC_OCT:  base <= itf_pkg::BASE_OCT;
        itf_pkg::FUNC_LHEX: base <= itf_pkg::BASE_HEX;
        itf_pkg::FUNC_UHEX: base <= itf_pkg::BASE_HEX;
        default:            base <= itf_pkg::BASE_DEC;
      endcase
    end else if (uword.op == itf_pkg::OP_EXTRACT) begin
      mag <= quo;
    end
  end

  // Digit stack: push while extracting, pop most significant first
  always_ff @(posedge clk) begin
    if (uword.op == itf_pkg::OP_EXTRACT) begin
      stack[0] <= dig_ch;
      for (int i = 1; i < itf_pkg::DIG_MAX; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (fire && (uword.chr_sel == itf_pkg::CHR_DIGIT)) begin
      for (int i = 0; i < itf_pkg::DIG_MAX - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uword.op == itf_pkg::OP_SETUP) begin
      pad   <= pad_calc;
      precx <= precx_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nd         <= '0;
      chars_left <= '0;
      emit_cnt   <= '0;
    end else begin
      if (in_beat) begin
        nd <= '0;
      end else if (uword.op == itf_pkg::OP_EXTRACT) begin
        nd <= nd + itf_pkg::DIG_W'(1);
      end
      if (uword.op == itf_pkg::OP_SETUP) begin
        chars_left <= pre_len + pad_calc + precx_calc + used;
      end else if (fire) begin
        chars_left <= chars_left - CW'(1);
      end
      if (uword.op == itf_pkg::OP_EMIT) begin
        if (step_done) begin
          emit_cnt <= '0;
        end else if (fire) begin
          emit_cnt <= emit_cnt + CW'(1);
        end
      end
    end
  end

  // Output register: hold the beat while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char <= ch;
      last     <= (chars_left == CW'(1));
    end
  end

endmodule

`default_nettype wire

// ===== hdl/integer_to_text_formatter_unit.sv =====
// The item is accepted, then one digit is extracted per cycle (1 to 11, decimal
// through a reciprocal multiply), then a set-up step, then the text goes out at one
// character a cycle while the output is not stalled; an empty run still takes a
// step of its own. The next item enters once the last character is in the output
// register. Reset: synchronous, clears the step register, the counts and the output
// valid; no clearing pass.
`default_nettype none

module integer_to_text_formatter_unit #(
  parameter int MAX_WIDTH     = itf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PRECISION = itf_pkg::DEF_MAX_PRECISION
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [31:0]         value,
  input  wire  [2:0]          func,
  input  wire                 zero_pad,
  input  wire                 left_align,
  input  wire                 alternate,
  input  wire                 force_plus,
  input  wire  [5:0]          field_width,
  input  wire  signed [5:0]   min_digits,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_char,
  output logic                last
);

  itf_pkg::step_t   step;
  itf_pkg::uword_t  uword;
  itf_pkg::status_t status;

  assign in_stall = (uword.op != itf_pkg::OP_WAIT);

  itf_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .step   (step),
    .uword  (uword)
  );

  itf_dpath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .uword       (uword),
    .status      (status),
    .in_valid    (in_valid),
    .value       (value),
    .func        (func),
    .zero_pad    (zero_pad),
    .left_align  (left_align),
    .alternate   (alternate),
    .force_plus  (force_plus),
    .field_width (field_width),
    .min_digits  (min_digits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last        (last)
  );

  // Every character of the previous item is out before the next one is taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (step == itf_pkg::ST_IDLE) |-> status.chars_zero)
    else $error("item accepted with characters still owed");

  a_beat_extract: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (step == itf_pkg::ST_EXTRACT))
    else $error("input beat did not start digit extraction");

  a_extract_exit: assert property (@(posedge clk) disable iff (rst)
    (step == itf_pkg::ST_EXTRACT) |=>
      ((step == itf_pkg::ST_EXTRACT) || (step == itf_pkg::ST_SETUP)))
    else $error("extraction left to an unexpected step");

  // Hold a stalled output beat unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_char) && $stable(last)))
    else $error("stalled output beat changed");

endmodule

`default_nettype wire
